@@ design/irptm_pkg.sv @@
// ----------------------------------------------------------------------------
// irptm_pkg
// Shared types and constants of the infrared pulse template matcher.
// ----------------------------------------------------------------------------
package irptm_pkg;

	typedef enum logic [1:0] {
		KIND_FALL = 2'd0,
		KIND_RISE = 2'd1,
		KIND_WORD = 2'd2,
		KIND_LEN  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  key_index;
		logic [6:0]  position;
		logic [15:0] value;
		logic [31:0] edge_tick;
	} item_t;

	typedef struct packed {
		logic       clear_timer;
		logic       match_done;
		logic       matched;
		logic [2:0] key;
	} result_t;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_DECODE_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS     = 2'd2;

	localparam logic [7:0] TOLERANCE_RESET = 8'd15;
	localparam logic [7:0] GAP_TICKS_RESET = 8'd10;

	localparam int unsigned RESTART_MARGIN = 10;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_CAP   = 3'd1,
		OP_WORD  = 3'd2,
		OP_LEN   = 3'd3,
		OP_MATCH = 3'd4
	} op_t;

	typedef struct packed {
		op_t  op;
		logic clr;
	} cmd_ctl_t;

endpackage

@@ design/irptm_front.sv @@
// ----------------------------------------------------------------------------
// irptm_front
// Classifies each accepted item, keeps the frame bookkeeping and issues one
// command per item to the back end.
// ----------------------------------------------------------------------------
module irptm_front import irptm_pkg::*; #(
	parameter int unsigned KEY_COUNT   = 6,
	parameter int unsigned FRAME_DEPTH = 100,
	localparam int unsigned WAW = $clog2(KEY_COUNT * FRAME_DEPTH)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  item_t          item,
	input  logic           decode_enable,
	input  logic [7:0]     gap_ticks,
	output cmd_ctl_t       cmd_ctl,
	output logic [WAW-1:0] cmd_addr,
	output logic [15:0]    cmd_data
);

	localparam int unsigned LW = $clog2(FRAME_DEPTH + 1);
	localparam logic [LW-1:0] DEPTH_L   = LW'(FRAME_DEPTH);
	localparam logic [LW-1:0] RESTART_L = LW'(FRAME_DEPTH - RESTART_MARGIN);

	logic [LW-1:0] count_q, count_d;
	logic [31:0]   last_tick_q, last_tick_d;
	logic          pend_q, pend_d;
	logic [LW-1:0] len0_q, len0_d;

	logic          key_ok, pos_ok, len_ok, restart, pend_now;
	logic [31:0]   limit;
	logic [LW-1:0] cnt0, cnt_rise;
	logic [WAW-1:0] word_addr;

	always_comb begin
		key_ok    = 32'(item.key_index) < KEY_COUNT;
		pos_ok    = 32'(item.position) < FRAME_DEPTH;
		len_ok    = 32'(item.value) <= FRAME_DEPTH;
		limit     = last_tick_q + 32'(gap_ticks);
		restart   = (count_q > RESTART_L) || (item.edge_tick > limit);
		cnt0      = restart ? '0 : count_q;
		cnt_rise  = count_q + 1'b1;
		word_addr = WAW'(32'(item.key_index) * FRAME_DEPTH + 32'(item.position));
		pend_now  = pend_q | (decode_enable & (item.kind == KIND_FALL) & restart);

		cmd_ctl.op  = OP_NONE;
		cmd_ctl.clr = 1'b0;
		cmd_addr    = '0;
		cmd_data    = item.value;
		count_d     = count_q;
		last_tick_d = last_tick_q;
		pend_d      = pend_q;
		len0_d      = len0_q;

		case (item.kind)
			KIND_WORD: begin
				if (key_ok && pos_ok) begin
					cmd_ctl.op = OP_WORD;
					cmd_addr   = word_addr;
				end
			end
			KIND_LEN: begin
				if (key_ok && len_ok) begin
					cmd_ctl.op = OP_LEN;
					cmd_addr   = WAW'(item.key_index);
					if (item.key_index == 3'd0) begin
						len0_d = LW'(item.value);
					end
				end
			end
			KIND_FALL: begin
				if (decode_enable) begin
					if (cnt0 < DEPTH_L) begin
						cmd_ctl.op = OP_CAP;
						cmd_addr   = WAW'(cnt0);
						count_d    = cnt0 + 1'b1;
					end else begin
						count_d = cnt0;
					end
				end
				cmd_ctl.clr = pend_now;
				pend_d      = 1'b0;
				last_tick_d = item.edge_tick;
			end
			KIND_RISE: begin
				if (decode_enable && (count_q < DEPTH_L)) begin
					cmd_addr = WAW'(count_q);
					if (len0_q == cnt_rise) begin
						cmd_ctl.op = OP_MATCH;
						count_d    = '0;
					end else begin
						cmd_ctl.op = OP_CAP;
						count_d    = cnt_rise;
					end
				end
				cmd_ctl.clr = pend_now;
				pend_d      = 1'b0;
				last_tick_d = item.edge_tick;
			end
			default: begin
				cmd_ctl.op = OP_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			last_tick_q <= '0;
			pend_q      <= 1'b1;
			len0_q      <= '0;
		end else if (accept) begin
			count_q     <= count_d;
			last_tick_q <= last_tick_d;
			pend_q      <= pend_d;
			len0_q      <= len0_d;
		end
	end

endmodule

@@ design/irptm_queue.sv @@
// ----------------------------------------------------------------------------
// irptm_queue
// Short first-in first-out command queue between front and back end.
// ----------------------------------------------------------------------------
module irptm_queue import irptm_pkg::*; #(
	parameter int unsigned W     = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_P = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == DEPTH_C);
	assign empty   = (count_q == '0);
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_P) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_P) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/irptm_back.sv @@
// ----------------------------------------------------------------------------
// irptm_back
// Executes commands: capture and template writes, length loads and the
// template match sweep, and holds the result register.
// ----------------------------------------------------------------------------
module irptm_back import irptm_pkg::*; #(
	parameter int unsigned KEY_COUNT   = 6,
	parameter int unsigned FRAME_DEPTH = 100,
	localparam int unsigned WAW = $clog2(KEY_COUNT * FRAME_DEPTH)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  cmd_ctl_t       cmd_ctl,
	input  logic [WAW-1:0] cmd_addr,
	input  logic [15:0]    cmd_data,
	output logic           cmd_take,
	input  logic [7:0]     tolerance,
	output logic           empty,
	input  logic           pop,
	output result_t        result
);

	localparam int unsigned LW     = $clog2(FRAME_DEPTH + 1);
	localparam int unsigned CAW    = $clog2(FRAME_DEPTH);
	localparam int unsigned KW     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int unsigned WDEPTH = KEY_COUNT * FRAME_DEPTH;
	localparam logic [KW-1:0]  LAST_K  = KW'(KEY_COUNT - 1);
	localparam logic [WAW-1:0] STRIDE  = WAW'(FRAME_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} back_st_t;

	back_st_t state_q;

	logic [15:0]      word_mem [WDEPTH];
	logic [15:0]      cap_mem [FRAME_DEPTH];
	logic [FRAME_DEPTH-1:0] cap_vld_q;
	logic [LW-1:0]    len_q [KEY_COUNT];

	logic [KW-1:0]    k_q;
	logic [LW-1:0]    t_q;
	logic [WAW-1:0]   base_q;
	logic             cmp_v_s1, last_s1, capv_s1;
	logic [15:0]      cap_s1, word_s1;
	logic             clr_q, hit_q, out_v_q;
	result_t          res_q;

	logic             slot_free, take, is_cap;
	logic [LW-1:0]    len_cur;
	logic             len_zero, last_k, issue, abort, found, elem_ok;
	logic [15:0]      cap_val;
	logic [16:0]      diff, adiff;

	assign slot_free = !out_v_q || pop;
	assign take      = cmd_valid && (state_q == ST_IDLE) && slot_free;
	assign cmd_take  = take;
	assign is_cap    = (cmd_ctl.op == OP_CAP) || (cmd_ctl.op == OP_MATCH);
	assign empty     = !out_v_q;
	assign result    = res_q;

	always_comb begin
		len_cur  = len_q[k_q];
		len_zero = (len_cur == '0);
		last_k   = (k_q == LAST_K);
		cap_val  = capv_s1 ? cap_s1 : 16'd0;
		diff     = {1'b0, cap_val} - {1'b0, word_s1};
		adiff    = diff[16] ? (17'd0 - diff) : diff;
		elem_ok  = adiff < {9'd0, tolerance};
		abort    = (state_q == ST_RUN) && (len_zero || (cmp_v_s1 && !elem_ok));
		found    = (state_q == ST_RUN) && !len_zero && cmp_v_s1 && elem_ok && last_s1;
		issue    = (state_q == ST_RUN) && !len_zero && !abort && !found && (t_q < len_cur);
	end

	always_ff @(posedge clk) begin
		if (take && is_cap) begin
			cap_mem[cmd_addr[CAW-1:0]] <= cmd_data;
		end
		if (take && (cmd_ctl.op == OP_WORD)) begin
			word_mem[cmd_addr] <= cmd_data;
		end
		if (issue) begin
			cap_s1  <= cap_mem[t_q[CAW-1:0]];
			capv_s1 <= cap_vld_q[t_q[CAW-1:0]];
			word_s1 <= word_mem[base_q + WAW'(t_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_vld_q <= '0;
			for (int i = 0; i < KEY_COUNT; i++) begin
				len_q[i] <= '0;
			end
		end else if (take) begin
			if (is_cap) begin
				cap_vld_q[cmd_addr[CAW-1:0]] <= 1'b1;
			end
			if (cmd_ctl.op == OP_MATCH) begin
				cap_vld_q[0] <= 1'b0;
			end
			if (cmd_ctl.op == OP_LEN) begin
				len_q[cmd_addr[KW-1:0]] <= cmd_data[LW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			k_q      <= '0;
			t_q      <= '0;
			base_q   <= '0;
			cmp_v_s1 <= 1'b0;
			last_s1  <= 1'b0;
			clr_q    <= 1'b0;
			hit_q    <= 1'b0;
			out_v_q  <= 1'b0;
			res_q    <= '0;
		end else begin
			if (pop) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (cmd_ctl.op == OP_MATCH) begin
							state_q  <= ST_RUN;
							k_q      <= '0;
							t_q      <= '0;
							base_q   <= '0;
							cmp_v_s1 <= 1'b0;
							clr_q    <= cmd_ctl.clr;
						end else begin
							out_v_q           <= 1'b1;
							res_q.clear_timer <= cmd_ctl.clr;
							res_q.match_done  <= 1'b0;
							res_q.matched     <= 1'b0;
							res_q.key         <= '0;
						end
					end
				end
				ST_RUN: begin
					cmp_v_s1 <= issue;
					last_s1  <= (t_q == len_cur - 1'b1);
					if (issue) begin
						t_q <= t_q + 1'b1;
					end
					if (found) begin
						hit_q   <= 1'b1;
						state_q <= ST_DONE;
					end else if (abort) begin
						if (last_k) begin
							hit_q   <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							k_q      <= k_q + 1'b1;
							base_q   <= base_q + STRIDE;
							t_q      <= '0;
							cmp_v_s1 <= 1'b0;
						end
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						out_v_q           <= 1'b1;
						res_q.clear_timer <= clr_q;
						res_q.match_done  <= 1'b1;
						res_q.matched     <= hit_q;
						res_q.key         <= hit_q ? 3'(k_q) : 3'd0;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/ir_pulse_template_matcher_core.sv @@
// ----------------------------------------------------------------------------
// ir_pulse_template_matcher_core
// Infrared pulse template matcher: stores edge captures of a frame and
// compares a finished frame against the stored key templates.
// ----------------------------------------------------------------------------
//  channel  | ports                          | beat taken when
//  ---------+--------------------------------+-------------------------
//  item     | push, full, item               | push && !full
//  result   | empty, pop, result             | pop && !empty
//  config   | cfg_we, cfg_idx, cfg_data      | cfg_we
//
//  Loads and edges that start no match go straight to the result register.
//  A match sweep walks the templates in key order and stops at the first
//  key that fits; the template word memory yields one word per cycle while
//  a template is read. Reset clears control, lengths and capture valid bits
//  at once; no clearing pass. The front takes items while the two-entry
//  command queue has room; the back waits on the result register.
// ----------------------------------------------------------------------------
module ir_pulse_template_matcher_core import irptm_pkg::*; #(
	parameter int unsigned KEY_COUNT   = 6,
	parameter int unsigned FRAME_DEPTH = 100
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  item_t                 item,
	output logic                  empty,
	input  logic                  pop,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned WAW     = $clog2(KEY_COUNT * FRAME_DEPTH);
	localparam int unsigned QDEPTH  = 2;
	localparam int unsigned QW      = $bits(cmd_ctl_t) + WAW + 16;

	logic       decode_enable_q;
	logic [7:0] tolerance_q, gap_ticks_q;

	logic           accept;
	cmd_ctl_t       f_ctl, b_ctl;
	logic [WAW-1:0] f_addr, b_addr;
	logic [15:0]    f_data, b_data;
	logic [QW-1:0]  q_wdata, q_rdata;
	logic           q_push, q_full, q_pop, q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_enable_q <= 1'b0;
			tolerance_q     <= TOLERANCE_RESET;
			gap_ticks_q     <= GAP_TICKS_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DECODE_ENABLE: decode_enable_q <= cfg_data[0];
				REG_TOLERANCE:     tolerance_q     <= cfg_data[7:0];
				REG_GAP_TICKS:     gap_ticks_q     <= cfg_data[7:0];
				default:           decode_enable_q <= decode_enable_q;
			endcase
		end
	end

	assign full    = q_full;
	assign accept  = push && !q_full;
	assign q_push  = accept;
	assign q_wdata = {f_ctl, f_addr, f_data};
	assign {b_ctl, b_addr, b_data} = q_rdata;

	irptm_front #(
		.KEY_COUNT   (KEY_COUNT),
		.FRAME_DEPTH (FRAME_DEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.item          (item),
		.decode_enable (decode_enable_q),
		.gap_ticks     (gap_ticks_q),
		.cmd_ctl       (f_ctl),
		.cmd_addr      (f_addr),
		.cmd_data      (f_data)
	);

	irptm_queue #(
		.W     (QW),
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	irptm_back #(
		.KEY_COUNT   (KEY_COUNT),
		.FRAME_DEPTH (FRAME_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!q_empty),
		.cmd_ctl   (b_ctl),
		.cmd_addr  (b_addr),
		.cmd_data  (b_data),
		.cmd_take  (q_pop),
		.tolerance (tolerance_q),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

`ifndef SYNTHESIS
	a_take_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !empty) |-> pop)
		else $error("command taken while result register blocked");

	a_take_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command taken from empty queue");

	a_no_attempt_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.match_done) |-> (!result.matched && (result.key == 3'd0)))
		else $error("match fields set without a match attempt");

	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.matched) |-> (32'(result.key) < KEY_COUNT))
		else $error("matched key out of range");
`endif

endmodule

@@ verif/ir_pulse_template_matcher_core_test.sv @@
// ----------------------------------------------------------------------------
// ir_pulse_template_matcher_core_test
// Drives edge captures and template loads into the matcher core through its
// queue ports and checks every result beat against a cycle-free predictor of
// the frame buffer and the template sweep. Directed cases cover the clear
// request after reset, ignored loads, the tolerance boundary, tick wrap and a
// full buffer; random phases then run well-formed frames under several
// register settings with noise mixed in.
// ----------------------------------------------------------------------------
module ir_pulse_template_matcher_core_test import irptm_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEYS  = 6;
	localparam int DEPTH = 100;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  push     = 1'b0;
	logic                  full;
	item_t                 item     = '0;
	logic                  empty;
	logic                  pop      = 1'b0;
	result_t               result;
	logic                  cfg_we   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	ir_pulse_template_matcher_core #(
		.KEY_COUNT   (KEYS),
		.FRAME_DEPTH (DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [15:0] tmpl_word [KEYS][DEPTH];
	bit          tmpl_seen [KEYS][DEPTH];
	int          tmpl_len  [KEYS];
	logic [15:0] frame_buf [DEPTH];
	int          frame_cnt = 0;
	logic [31:0] last_tick = '0;
	bit          clr_due   = 1'b1;
	bit          cfg_en    = 1'b0;
	int          cfg_tol   = TOLERANCE_RESET;
	int          cfg_gap   = GAP_TICKS_RESET;

	result_t result_due [$];
	int      fails      = 0;
	int      beats_sent = 0;
	int      pop_hold   = 0;
	bit      calm       = 1'b0;

	initial begin
		for (int k = 0; k < KEYS; k++) begin
			tmpl_len[k] = 0;
			for (int p = 0; p < DEPTH; p++) begin
				tmpl_word[k][p] = '0;
				tmpl_seen[k][p] = 1'b0;
			end
		end
		for (int p = 0; p < DEPTH; p++)
			frame_buf[p] = '0;
	end

	function automatic bit frame_fits(int k);
		int c;
		int w;
		if (tmpl_len[k] == 0 || tmpl_len[k] > DEPTH)
			return 1'b0;
		for (int t = 0; t < tmpl_len[k]; t++) begin
			c = frame_buf[t];
			w = tmpl_word[k][t];
			if (!(c < w + cfg_tol && c > w - cfg_tol))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic result_t decode_item(item_t it);
		result_t     r;
		logic [31:0] lim;
		r = '0;
		case (it.kind)
			KIND_WORD: begin
				if (it.key_index < KEYS && it.position < DEPTH) begin
					tmpl_word[it.key_index][it.position] = it.value;
					tmpl_seen[it.key_index][it.position] = 1'b1;
				end
			end
			KIND_LEN: begin
				if (it.key_index < KEYS && it.value <= DEPTH)
					tmpl_len[it.key_index] = it.value;
			end
			default: begin
				if (cfg_en) begin
					if (it.kind == KIND_FALL) begin
						lim = last_tick + 32'(cfg_gap);
						if (frame_cnt > DEPTH - RESTART_MARGIN || it.edge_tick > lim) begin
							frame_cnt = 0;
							clr_due = 1'b1;
						end
						if (frame_cnt < DEPTH) begin
							frame_buf[frame_cnt] = it.value;
							frame_cnt++;
						end
					end else if (frame_cnt < DEPTH) begin
						frame_buf[frame_cnt] = it.value;
						frame_cnt++;
						if (tmpl_len[0] == frame_cnt) begin
							frame_buf[0] = '0;
							frame_cnt = 0;
							r.match_done = 1'b1;
							for (int k = 0; k < KEYS; k++) begin
								if (!r.matched && frame_fits(k)) begin
									r.matched = 1'b1;
									r.key = 3'(k);
								end
							end
						end
					end
				end
				last_tick = it.edge_tick;
				if (clr_due) begin
					r.clear_timer = 1'b1;
					clr_due = 1'b0;
				end
			end
		endcase
		return r;
	endfunction

	function automatic int words_ready(int k);
		int n;
		n = 0;
		while (n < DEPTH && tmpl_seen[k][n])
			n++;
		return n;
	endfunction

	function automatic item_t pack_item(kind_t kd, int kidx, int pos, int val,
		logic [31:0] tick);
		item_t it;
		it.kind = kd;
		it.key_index = kidx[2:0];
		it.position = pos[6:0];
		it.value = val[15:0];
		it.edge_tick = tick;
		return it;
	endfunction

	function automatic int near_word(int w, bit spoil);
		int d;
		if (spoil) begin
			d = cfg_tol + int'($urandom_range(0, 40));
			if ($urandom_range(0, 1))
				d = -d;
		end else if (cfg_tol > 0) begin
			d = int'($urandom_range(0, 2 * cfg_tol - 2)) - (cfg_tol - 1);
		end else begin
			d = 0;
		end
		w += d;
		if (w < 0)
			w = 0;
		if (w > 65535)
			w = 65535;
		return w;
	endfunction

	function automatic item_t noise_item();
		item_t it;
		int    lim;
		it = pack_item(kind_t'($urandom_range(0, 3)), $urandom_range(0, 7),
			$urandom_range(0, 127), $urandom_range(0, 65535),
			$urandom_range(0, 1) ? $urandom : last_tick + $urandom_range(0, 300));
		if (it.kind == KIND_LEN && it.key_index < KEYS && it.value <= DEPTH) begin
			lim = words_ready(it.key_index);
			if (it.value > lim)
				it.value = 16'($urandom_range(0, lim));
		end
		return it;
	endfunction

	task automatic send_item(input item_t it);
		push <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (full !== 1'b0);
		result_due.push_back(decode_item(it));
		beats_sent++;
		if (!calm && $urandom_range(0, 9) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (result_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val[7:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DECODE_ENABLE: cfg_en = val[0];
			REG_TOLERANCE:     cfg_tol = val & 255;
			REG_GAP_TICKS:     cfg_gap = val & 255;
			default: ;
		endcase
	endtask

	task automatic load_templates();
		bit big;
		int n;
		int alt;
		int len;
		big = ($urandom_range(0, 7) == 0);
		n = big ? 2 * $urandom_range(10, 46) : 2 * $urandom_range(1, 6);
		alt = $urandom_range(1, KEYS - 1);
		for (int k = 0; k < KEYS; k++) begin
			if (!big || k == 0 || k == alt) begin
				for (int p = 0; p < n; p++)
					send_item(pack_item(KIND_WORD, k, p,
						p == 0 ? $urandom_range(0, cfg_tol > 1 ? cfg_tol - 1 : 0)
						: $urandom_range(0, 65535), $urandom));
				len = (k == 0 || $urandom_range(0, 3) != 0) ? n : $urandom_range(0, n);
				send_item(pack_item(KIND_LEN, k, $urandom_range(0, 127), len, $urandom));
			end
		end
	endtask

	task automatic run_frame();
		int          k;
		int          n;
		int          bad;
		int          w;
		logic [31:0] tk;
		kind_t       kd;
		k = $urandom_range(0, KEYS - 1);
		n = tmpl_len[0];
		if (n < 2)
			n = 2 + 2 * $urandom_range(0, 3);
		bad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : -1;
		for (int t = 0; t < n; t++) begin
			kd = (t % 2 == 0) ? KIND_FALL : KIND_RISE;
			if (t == 0) begin
				tk = last_tick + 32'(cfg_gap) + 1 + $urandom_range(0, 5000);
				w = $urandom_range(0, 65535);
			end else begin
				tk = last_tick + $urandom_range(0, cfg_gap);
				w = near_word(tmpl_word[k][t], t == bad);
			end
			send_item(pack_item(kd, $urandom_range(0, 7), $urandom_range(0, 127), w, tk));
		end
	endtask

	task automatic run_phase(input int en, input int tol, input int gap, input int budget);
		int start;
		int pick;
		write_reg(REG_DECODE_ENABLE, en);
		write_reg(REG_TOLERANCE, tol);
		write_reg(REG_GAP_TICKS, gap);
		start = beats_sent;
		load_templates();
		while (beats_sent - start < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				run_frame();
			else if (pick < 72)
				load_templates();
			else
				repeat ($urandom_range(1, 6)) send_item(noise_item());
		end
		wait_idle();
	endtask

	task automatic test_clear_after_reset();
		send_item(pack_item(KIND_RISE, 0, 0, 16'hFFFF, 32'd5));
		send_item(pack_item(KIND_FALL, 7, 127, 0, 32'd0));
	endtask

	task automatic test_template_loads();
		send_item(pack_item(KIND_WORD, 6, 0, 16'h1234, 0));
		send_item(pack_item(KIND_WORD, 7, 5, 16'h4321, 0));
		send_item(pack_item(KIND_WORD, 0, 100, 16'hAAAA, 0));
		send_item(pack_item(KIND_WORD, 0, 127, 16'h5555, 0));
		send_item(pack_item(KIND_LEN, 0, 0, 101, 0));
		send_item(pack_item(KIND_LEN, 0, 0, 65535, 0));
		send_item(pack_item(KIND_LEN, 6, 0, 0, 0));
		send_item(pack_item(KIND_LEN, 7, 0, 2, 0));
		send_item(pack_item(KIND_WORD, 0, 0, 3, 0));
		send_item(pack_item(KIND_WORD, 0, 1, 200, 0));
		send_item(pack_item(KIND_WORD, 1, 0, 0, 0));
		send_item(pack_item(KIND_WORD, 1, 1, 500, 0));
		send_item(pack_item(KIND_LEN, 0, 0, 2, 0));
		send_item(pack_item(KIND_LEN, 1, 0, 2, 0));
	endtask

	task automatic test_match_tolerance();
		write_reg(REG_DECODE_ENABLE, 1);
		write_reg(REG_TOLERANCE, 15);
		write_reg(REG_GAP_TICKS, 10);
		send_item(pack_item(KIND_FALL, 0, 0, 777, last_tick + 11));
		send_item(pack_item(KIND_RISE, 0, 0, 500, last_tick + 10));
		send_item(pack_item(KIND_FALL, 0, 0, 1, last_tick + 11));
		send_item(pack_item(KIND_RISE, 0, 0, 515, last_tick + 10));
		send_item(pack_item(KIND_FALL, 0, 0, 1, last_tick + 20));
		send_item(pack_item(KIND_RISE, 0, 0, 214, last_tick));
	endtask

	task automatic test_tick_wrap();
		send_item(pack_item(KIND_FALL, 0, 0, 40, 32'hFFFF_FFFA));
		send_item(pack_item(KIND_FALL, 0, 0, 41, 32'h0000_0002));
		send_item(pack_item(KIND_FALL, 0, 0, 42, 32'h0000_0005));
	endtask

	task automatic test_buffer_full();
		send_item(pack_item(KIND_LEN, 0, 0, 0, 0));
		repeat (DEPTH + 3)
			send_item(pack_item(KIND_RISE, 0, 0, $urandom_range(0, 65535), last_tick));
		send_item(pack_item(KIND_FALL, 0, 0, 9, last_tick));
	endtask

	task automatic test_random_traffic();
		run_phase(1, 15, 10, 140);
		run_phase(1, 0, 0, 120);
		run_phase(1, 255, 255, 120);
		run_phase(1, 1, $urandom_range(0, 255), 120);
		run_phase(0, $urandom_range(0, 255), $urandom_range(0, 255), 60);
		calm = 1'b1;
		run_phase(1, $urandom_range(2, 60), $urandom_range(0, 255), 190);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			if (result_due.size() == 0) begin
				$error("result beat with nothing expected: %p", result);
				fails++;
			end else begin
				want = result_due.pop_front();
				if (result.clear_timer !== want.clear_timer) begin
					$error("clear_timer: expected %0d, got %0d", want.clear_timer, result.clear_timer);
					fails++;
				end
				if (result.match_done !== want.match_done) begin
					$error("match_done: expected %0d, got %0d", want.match_done, result.match_done);
					fails++;
				end
				if (result.matched !== want.matched) begin
					$error("matched: expected %0d, got %0d", want.matched, result.matched);
					fails++;
				end
				if (result.key !== want.key) begin
					$error("key: expected %0d, got %0d", want.key, result.key);
					fails++;
				end
			end
		end
		if (pop_hold > 0) begin
			pop_hold--;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			pop_hold = $urandom_range(1, 18) - 1;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	initial begin
		#50ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_clear_after_reset();
		test_template_loads();
		test_match_tolerance();
		test_tick_wrap();
		test_buffer_full();
		test_random_traffic();
		wait_idle();
		repeat (20) @(posedge clk);
		if (fails == 0 && result_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
design/irptm_pkg.sv
design/irptm_front.sv
design/irptm_queue.sv
design/irptm_back.sv
design/ir_pulse_template_matcher_core.sv
verif/ir_pulse_template_matcher_core_test.sv
